[hdl/tbw_pkg.sv]
// Shared widths and types for the barycentric weight pipeline.
package tbw_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int WOUT_W  = 24;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [WOUT_W-1:0]  weight_t;

  typedef struct packed {
    prod_t s;
    prod_t nb;
    prod_t nc;
  } cross_t;

endpackage

[hdl/tbw_cross.sv]
// Edge vectors, products and cross-product areas in three register stages.
module tbw_cross
  import tbw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  coord_t ax,
  input  coord_t ay,
  input  coord_t bx,
  input  coord_t by_coord,
  input  coord_t cx,
  input  coord_t cy,
  input  coord_t px,
  input  coord_t py,
  output logic   valid,
  output cross_t xprod
);

  logic  v1_r, v2_r, v3_r;
  diff_t abx_r, aby_r, acx_r, acy_r, apx_r, apy_r;
  prod_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  cross_t cross_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abx_r <= DIFF_W'(bx) - DIFF_W'(ax);
      aby_r <= DIFF_W'(by_coord) - DIFF_W'(ay);
      acx_r <= DIFF_W'(cx) - DIFF_W'(ax);
      acy_r <= DIFF_W'(cy) - DIFF_W'(ay);
      apx_r <= DIFF_W'(px) - DIFF_W'(ax);
      apy_r <= DIFF_W'(py) - DIFF_W'(ay);
      p0_r  <= abx_r * acy_r;
      p1_r  <= aby_r * acx_r;
      p2_r  <= apx_r * acy_r;
      p3_r  <= apy_r * acx_r;
      p4_r  <= abx_r * apy_r;
      p5_r  <= aby_r * apx_r;
      cross_r.s  <= p0_r - p1_r;
      cross_r.nb <= p2_r - p3_r;
      cross_r.nc <= p4_r - p5_r;
    end
  end

  assign valid = v3_r;
  assign xprod = cross_r;

endmodule

[hdl/tbw_div.sv]
// Pipelined restoring divider: one quotient bit per stage for both numerators.
module tbw_div
  import tbw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  cross_t                       xprod,
  output logic                         valid,
  output logic [MAG_W+FRAC_BITS-1:0]   qb_mag,
  output logic [MAG_W+FRAC_BITS-1:0]   qc_mag,
  output logic                         neg_b,
  output logic                         neg_c,
  output logic                         deg
);

  localparam int DW = MAG_W + FRAC_BITS;

  logic             v_r    [0:DW];
  logic [DW-1:0]    dvb_r  [0:DW];
  logic [DW-1:0]    dvc_r  [0:DW];
  logic [DW-1:0]    qb_r   [0:DW];
  logic [DW-1:0]    qc_r   [0:DW];
  logic [MAG_W-1:0] rb_r   [0:DW];
  logic [MAG_W-1:0] rc_r   [0:DW];
  logic [MAG_W-1:0] d_r    [0:DW];
  logic             nb_r   [0:DW];
  logic             nc_r   [0:DW];
  logic             dg_r   [0:DW];

  logic [MAG_W-1:0] nbm, ncm, sm;

  assign nbm = xprod.nb[PROD_W-1] ? MAG_W'(-xprod.nb) : MAG_W'(xprod.nb);
  assign ncm = xprod.nc[PROD_W-1] ? MAG_W'(-xprod.nc) : MAG_W'(xprod.nc);
  assign sm  = xprod.s[PROD_W-1]  ? MAG_W'(-xprod.s)  : MAG_W'(xprod.s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvb_r[0] <= {nbm, {FRAC_BITS{1'b0}}};
      dvc_r[0] <= {ncm, {FRAC_BITS{1'b0}}};
      qb_r[0]  <= '0;
      qc_r[0]  <= '0;
      rb_r[0]  <= '0;
      rc_r[0]  <= '0;
      d_r[0]   <= sm;
      nb_r[0]  <= xprod.nb[PROD_W-1] ^ xprod.s[PROD_W-1];
      nc_r[0]  <= xprod.nc[PROD_W-1] ^ xprod.s[PROD_W-1];
      dg_r[0]  <= (xprod.s == '0);
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [MAG_W:0] trial_b, trial_c;
    logic           ge_b, ge_c;

    assign trial_b = {rb_r[k], dvb_r[k][DW-1]};
    assign trial_c = {rc_r[k], dvc_r[k][DW-1]};
    assign ge_b    = trial_b >= {1'b0, d_r[k]};
    assign ge_c    = trial_c >= {1'b0, d_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvb_r[k+1] <= {dvb_r[k][DW-2:0], 1'b0};
        dvc_r[k+1] <= {dvc_r[k][DW-2:0], 1'b0};
        qb_r[k+1]  <= {qb_r[k][DW-2:0], ge_b};
        qc_r[k+1]  <= {qc_r[k][DW-2:0], ge_c};
        rb_r[k+1]  <= ge_b ? MAG_W'(trial_b - {1'b0, d_r[k]}) : MAG_W'(trial_b);
        rc_r[k+1]  <= ge_c ? MAG_W'(trial_c - {1'b0, d_r[k]}) : MAG_W'(trial_c);
        d_r[k+1]   <= d_r[k];
        nb_r[k+1]  <= nb_r[k];
        nc_r[k+1]  <= nc_r[k];
        dg_r[k+1]  <= dg_r[k];
      end
    end
  end

  assign valid  = v_r[DW];
  assign qb_mag = qb_r[DW];
  assign qc_mag = qc_r[DW];
  assign neg_b  = nb_r[DW];
  assign neg_c  = nc_r[DW];
  assign deg    = dg_r[DW];

endmodule

[hdl/tbw_final.sv]
// Sign fix-up, third weight, saturation and the output register.
module tbw_final
  import tbw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [MAG_W+FRAC_BITS-1:0]  qb_mag,
  input  logic [MAG_W+FRAC_BITS-1:0]  qc_mag,
  input  logic                        neg_b,
  input  logic                        neg_c,
  input  logic                        deg,
  output logic                        out_valid,
  output weight_t                     weight_a,
  output weight_t                     weight_b,
  output weight_t                     weight_c,
  output logic                        degenerate
);

  localparam int DW = MAG_W + FRAC_BITS;
  localparam int AW = DW + 3;
  localparam logic signed [AW-1:0] SMAX = (1 <<< (WOUT_W - 1)) - 1;
  localparam logic signed [AW-1:0] SMIN = -(1 <<< (WOUT_W - 1));
  localparam logic signed [AW-1:0] ONE  = AW'(1) << FRAC_BITS;

  function automatic weight_t sat(input logic signed [AW-1:0] v);
    weight_t r;
    if (v > SMAX) begin
      r = SMAX[WOUT_W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[WOUT_W-1:0];
    end else begin
      r = v[WOUT_W-1:0];
    end
    return r;
  endfunction

  logic signed [AW-1:0] wb, wc, wa;
  logic    valid_r, deg_r;
  weight_t wa_r, wb_r, wc_r;

  assign wb = neg_b ? -$signed(AW'(qb_mag)) : $signed(AW'(qb_mag));
  assign wc = neg_c ? -$signed(AW'(qc_mag)) : $signed(AW'(qc_mag));
  assign wa = ONE - wb - wc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= deg;
      wa_r  <= deg ? '0 : sat(wa);
      wb_r  <= deg ? '0 : sat(wb);
      wc_r  <= deg ? '0 : sat(wc);
    end
  end

  assign out_valid  = valid_r;
  assign weight_a   = wa_r;
  assign weight_b   = wb_r;
  assign weight_c   = wc_r;
  assign degenerate = deg_r;

endmodule

[hdl/triangle_barycentric_weights_top.sv]
// Top level of the barycentric weight pipeline.
// Path to out_valid: cross stages, divider stages, then the output register.
// One item per cycle unless stalled; the divider resolves one quotient bit per stage.
// A stalled output freezes every stage together, so no item is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module triangle_barycentric_weights_top
  import tbw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  coord_t  in_ax,
  input  coord_t  in_ay,
  input  coord_t  in_bx,
  input  coord_t  in_by_coord,
  input  coord_t  in_cx,
  input  coord_t  in_cy,
  input  coord_t  in_px,
  input  coord_t  in_py,
  output logic    out_valid,
  input  logic    out_ready,
  output weight_t out_weight_a,
  output weight_t out_weight_b,
  output weight_t out_weight_c,
  output logic    out_degenerate
);

  localparam int DW = MAG_W + FRAC_BITS;

  logic          adv;
  logic          cr_valid, dv_valid;
  cross_t        xprod;
  logic [DW-1:0] qb_mag, qc_mag;
  logic          neg_b, neg_c, deg;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  tbw_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .ax       (in_ax),
    .ay       (in_ay),
    .bx       (in_bx),
    .by_coord (in_by_coord),
    .cx       (in_cx),
    .cy       (in_cy),
    .px       (in_px),
    .py       (in_py),
    .valid    (cr_valid),
    .xprod    (xprod)
  );

  tbw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (cr_valid),
    .xprod    (xprod),
    .valid    (dv_valid),
    .qb_mag   (qb_mag),
    .qc_mag   (qc_mag),
    .neg_b    (neg_b),
    .neg_c    (neg_c),
    .deg      (deg)
  );

  tbw_final #(.FRAC_BITS(FRAC_BITS)) u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (dv_valid),
    .qb_mag     (qb_mag),
    .qc_mag     (qc_mag),
    .neg_b      (neg_b),
    .neg_c      (neg_c),
    .deg        (deg),
    .out_valid  (out_valid),
    .weight_a   (out_weight_a),
    .weight_b   (out_weight_b),
    .weight_c   (out_weight_c),
    .degenerate (out_degenerate)
  );

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0)
    else $error("degenerate item with nonzero weights");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule
